>>> rtl/icd_pkg.sv
// ----------------------------------------------------------------------------
// icd_pkg: shared types and constants for the ICMP covert channel detector
// Transfer payload structs, histogram control bundle and register indexes.
// ----------------------------------------------------------------------------
package icd_pkg;

   typedef struct packed {
      logic        opcode;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [31:0] time_seconds;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic       no_session;
      logic [6:0] session_index;
      logic       stimulus_alert;
      logic       length_alert;
      logic       time_alert;
      logic       content_alert;
   } rsp_type;

   typedef struct packed {
      logic       clear;
      logic       inc;
      logic [7:0] value;
   } hist_ctl_type;

   localparam int HIST_DEPTH = 256;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_BYTE   = 1'b1;

   localparam logic [1:0] CLASS_SHORT  = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [1:0] CLASS_LONG   = 2'd2;

   localparam logic [2:0] REG_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_SHORT   = 3'd1;
   localparam logic [2:0] REG_MEDIUM  = 3'd2;
   localparam logic [2:0] REG_MINPKT  = 3'd3;
   localparam logic [2:0] REG_REPEAT  = 3'd4;

   localparam logic [15:0] RST_TIMEOUT = 16'd60;
   localparam logic [15:0] RST_SHORT   = 16'd20;
   localparam logic [15:0] RST_MEDIUM  = 16'd500;
   localparam logic [4:0]  RST_MINPKT  = 5'd6;
   localparam logic [7:0]  RST_REPEAT  = 8'd6;

endpackage

>>> rtl/icmp_covert_channel_detector.sv
// ----------------------------------------------------------------------------
// icmp_covert_channel_detector: ICMP covert channel detector top level
// Session table, per-session packet window and alert evaluation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items: a header (opcode 0) followed by payload_length
//   payload bytes (opcode 1). rsp_* returns one result per completed packet,
//   at the last payload byte or right after a header with zero length.
//   psel/penable/pwrite/paddr/pwdata set thresholds; write only while idle.
// Sequence:
//   Header: a session table sweep (one read of the session memory per
//   cycle), a step to claim and append, then, when a slot is claimed, a
//   sweep of the window memory and a step to form alerts.
//   Payload byte: a read-modify-write of the histogram.
//   A result passes through the emit state, where it waits while the output
//   register still holds an unaccepted result.
// Reset: all sessions invalid, histogram cleared, thresholds at defaults.
// Stall: a pending result sits in the output register while new items are
//   taken; input is held off while an item is processed and while a second result must load.
// ----------------------------------------------------------------------------
module icmp_covert_channel_detector #(
   parameter int SESSION_SLOTS = 128,
   parameter int WINDOW_SLOTS  = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  icd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output icd_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import icd_pkg::*;

   localparam int SW    = $clog2(SESSION_SLOTS);
   localparam int WW    = $clog2(WINDOW_SLOTS);
   localparam int WMAX  = WINDOW_SLOTS - 1;       // entries kept per session
   localparam int WDEP  = SESSION_SLOTS * WINDOW_SLOTS;
   localparam int AW    = $clog2(WDEP);
   localparam int CW    = WW + 3;
   localparam int MW    = (WW > 5) ? WW : 5;

   typedef struct packed {
      logic [31:0]   addr_a;
      logic [31:0]   addr_b;
      logic [31:0]   last_seen;
      logic [WW-1:0] fill;
      logic [WW-1:0] head;    // ring start of the window
   } sess_type;

   typedef struct packed {
      logic        from_a;
      logic [1:0]  cls;
      logic [31:0] stamp;
   } win_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_WSCAN, S_ALERT, S_HUPD, S_EMIT
   } state_type;

   function automatic logic [WW-1:0] wrap_pos(input logic [WW:0] x);
      logic [WW:0] r;
      r = (x >= (WW+1)'(WMAX)) ? x - (WW+1)'(WMAX) : x;
      return r[WW-1:0];
   endfunction

   // configuration
   logic [15:0] timeout_ff, short_ff, medium_ff;
   logic [4:0]  minpkt_ff;
   logic [7:0]  repeat_ff;

   // memories
   sess_type sess_mem [SESSION_SLOTS];
   win_type  win_mem  [WDEP];
   sess_type sess_q_ff;
   win_type  win_q_ff;

   // control and header context
   state_type            state_ff;
   logic [31:0]          src_ff, dst_ff, now_ff;
   logic [15:0]          len_ff, rem_ff;
   logic                 pend_none_ff;
   logic [SESSION_SLOTS-1:0] valid_ff;
   logic [SW-1:0]        slot_ff;
   logic [SW:0]          scan_idx_ff;
   logic                 sv_ff;
   logic [SW-1:0]        sidx_ff;
   logic                 found_ff, free_ok_ff;
   logic [SW-1:0]        match_slot_ff, free_slot_ff;
   sess_type             match_rec_ff;
   logic [WW-1:0]        fill_ff, head_ff, k_ff;
   logic                 wv_ff, wlast_ff, prev_ok_ff;
   logic [31:0]          prev_time_ff;
   logic [WW-1:0]        ca_ff, cb_ff, sh_ff, md_ff, g0_ff, g1_ff, g2_ff, gl_ff;
   logic                 sa_ff, ra_ff, ta_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // combinational
   logic         req_fire;
   logic         sess_rd, sess_we, win_rd, win_we;
   logic [SW-1:0] sess_raddr;
   logic [AW-1:0] win_raddr, win_waddr;
   win_type      win_wdata;
   sess_type     sel_rec, new_rec;
   logic [SW-1:0] sel_slot;
   logic         have_slot, win_full;
   logic [WW-1:0] wr_pos;
   logic [1:0]   cls;
   logic         cur_vld, cur_match, cur_free;
   logic [31:0]  gap;
   logic         enough, stim, lenmix, timing;
   logic [CW-1:0] a2, b3, s5, m5;
   logic [SW+6:0] slot_wide;
   hist_ctl_type hist_ctl;
   logic         content;

   assign req_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;

   // ---------------- configuration port ----------------
   always_comb begin
      unique case (paddr[4:2])
         REG_TIMEOUT: prdata = {16'd0, timeout_ff};
         REG_SHORT:   prdata = {16'd0, short_ff};
         REG_MEDIUM:  prdata = {16'd0, medium_ff};
         REG_MINPKT:  prdata = {27'd0, minpkt_ff};
         REG_REPEAT:  prdata = {24'd0, repeat_ff};
         default:     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= RST_TIMEOUT;
         short_ff   <= RST_SHORT;
         medium_ff  <= RST_MEDIUM;
         minpkt_ff  <= RST_MINPKT;
         repeat_ff  <= RST_REPEAT;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            REG_TIMEOUT: timeout_ff <= pwdata[15:0];
            REG_SHORT:   short_ff   <= pwdata[15:0];
            REG_MEDIUM:  medium_ff  <= pwdata[15:0];
            REG_MINPKT:  minpkt_ff  <= pwdata[4:0];
            REG_REPEAT:  repeat_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- histogram unit ----------------
   always_comb begin
      hist_ctl.clear = req_fire && (req_data.opcode == OP_HEADER);
      hist_ctl.inc   = req_fire && (req_data.opcode == OP_BYTE) && (rem_ff != 16'd0);
      hist_ctl.value = req_data.payload_byte;
   end

   icd_hist u_hist (
      .clock (clock),
      .reset (reset),
      .ctl   (hist_ctl),
      .limit (repeat_ff),
      .alert (content)
   );

   // ---------------- session sweep ----------------
   // one read per cycle; data is judged in the following cycle
   always_comb begin
      sess_rd    = (state_ff == S_SCAN) && (scan_idx_ff < (SW+1)'(SESSION_SLOTS));
      sess_raddr = scan_idx_ff[SW-1:0];
      cur_vld    = valid_ff[sidx_ff];
      cur_match  = cur_vld &&
                   ((sess_q_ff.addr_a == src_ff && sess_q_ff.addr_b == dst_ff) ||
                    (sess_q_ff.addr_b == src_ff && sess_q_ff.addr_a == dst_ff));
      // expiry compare is exact, no wrap
      cur_free   = !cur_vld ||
                   (({1'b0, sess_q_ff.last_seen} + {17'd0, timeout_ff}) < {1'b0, now_ff});
   end

   // ---------------- claim and append ----------------
   always_comb begin
      have_slot = found_ff || free_ok_ff;
      if (found_ff) begin
         sel_slot           = match_slot_ff;
         sel_rec            = match_rec_ff;
         sel_rec.last_seen  = now_ff;
      end else begin
         sel_slot       = free_slot_ff;
         sel_rec.addr_a = src_ff;
         sel_rec.addr_b = dst_ff;
         sel_rec.last_seen = now_ff;
         sel_rec.fill   = '0;
         sel_rec.head   = '0;
      end
      win_full = sel_rec.fill == WW'(WMAX);
      new_rec  = sel_rec;
      if (win_full) begin
         // drop the oldest: overwrite at head, advance head
         wr_pos       = sel_rec.head;
         new_rec.head = wrap_pos({1'b0, sel_rec.head} + (WW+1)'(1));
      end else begin
         wr_pos       = wrap_pos({1'b0, sel_rec.head} + {1'b0, sel_rec.fill});
         new_rec.fill = sel_rec.fill + WW'(1);
      end
      if (len_ff < short_ff) begin
         cls = CLASS_SHORT;
      end else if (len_ff < medium_ff) begin
         cls = CLASS_MEDIUM;
      end else begin
         cls = CLASS_LONG;
      end
      sess_we          = (state_ff == S_DECIDE) && have_slot;
      win_we           = sess_we;
      win_waddr        = AW'(sel_slot) * AW'(WINDOW_SLOTS) + AW'(wr_pos);
      win_wdata.from_a = src_ff == sel_rec.addr_a;
      win_wdata.cls    = cls;
      win_wdata.stamp  = now_ff;
   end

   // ---------------- window sweep ----------------
   always_comb begin
      win_rd    = (state_ff == S_WSCAN) && (k_ff < fill_ff);
      win_raddr = AW'(slot_ff) * AW'(WINDOW_SLOTS) +
                  AW'(wrap_pos({1'b0, head_ff} + {1'b0, k_ff}));
      gap       = win_q_ff.stamp - prev_time_ff;
   end

   always_ff @(posedge clock) begin
      if (sess_rd) begin
         sess_q_ff <= sess_mem[sess_raddr];
      end
      if (sess_we) begin
         sess_mem[sel_slot] <= new_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (win_rd) begin
         win_q_ff <= win_mem[win_raddr];
      end
      if (win_we) begin
         win_mem[win_waddr] <= win_wdata;
      end
   end

   // ---------------- alert arithmetic ----------------
   always_comb begin
      a2     = CW'(ca_ff) << 1;
      b3     = CW'(cb_ff) + (CW'(cb_ff) << 1);
      s5     = CW'(sh_ff) + (CW'(sh_ff) << 2);
      m5     = CW'(md_ff) + (CW'(md_ff) << 2);
      enough = MW'(fill_ff) >= MW'(minpkt_ff);
      stim   = (a2 > b3) || (a2 < CW'(cb_ff));
      lenmix = (s5 > CW'(md_ff)) && (CW'(sh_ff) < m5) && (CW'(sh_ff) > CW'(3));
      timing = (CW'(g0_ff) > CW'(g1_ff) + CW'(3)) || (CW'(g2_ff) > CW'(6)) ||
               (CW'(gl_ff) > CW'(4));
      slot_wide = {7'd0, slot_ff};
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rem_ff       <= '0;
         pend_none_ff <= 1'b0;
         valid_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sv_ff        <= 1'b0;
         wv_ff        <= 1'b0;
      end else begin
         // the emit state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_data.opcode == OP_HEADER) begin
                     // a header abandons any packet still pending
                     src_ff      <= req_data.source_address;
                     dst_ff      <= req_data.dest_address;
                     now_ff      <= req_data.time_seconds;
                     len_ff      <= req_data.payload_length;
                     rem_ff      <= req_data.payload_length;
                     scan_idx_ff <= '0;
                     sv_ff       <= 1'b0;
                     found_ff    <= 1'b0;
                     free_ok_ff  <= 1'b0;
                     state_ff    <= S_SCAN;
                  end else if (rem_ff != 16'd0) begin
                     rem_ff   <= rem_ff - 16'd1;
                     state_ff <= S_HUPD;
                  end
               end
            end
            S_SCAN: begin
               sv_ff <= sess_rd;
               if (sess_rd) begin
                  sidx_ff     <= sess_raddr;
                  scan_idx_ff <= scan_idx_ff + (SW+1)'(1);
               end
               if (sv_ff) begin
                  if (cur_match && !found_ff) begin
                     found_ff      <= 1'b1;
                     match_slot_ff <= sidx_ff;
                     match_rec_ff  <= sess_q_ff;
                  end
                  if (cur_free && !free_ok_ff) begin
                     free_ok_ff   <= 1'b1;
                     free_slot_ff <= sidx_ff;
                  end
                  if (sidx_ff == SW'(SESSION_SLOTS - 1)) begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_DECIDE: begin
               if (have_slot) begin
                  valid_ff[sel_slot] <= 1'b1;
                  slot_ff      <= sel_slot;
                  fill_ff      <= new_rec.fill;
                  head_ff      <= new_rec.head;
                  pend_none_ff <= 1'b0;
                  k_ff         <= '0;
                  wv_ff        <= 1'b0;
                  prev_ok_ff   <= 1'b0;
                  ca_ff <= '0; cb_ff <= '0; sh_ff <= '0; md_ff <= '0;
                  g0_ff <= '0; g1_ff <= '0; g2_ff <= '0; gl_ff <= '0;
                  state_ff     <= S_WSCAN;
               end else begin
                  // table full: no session claimed, the result reports no_session
                  pend_none_ff <= 1'b1;
                  slot_ff      <= '0;
                  sa_ff        <= 1'b0;
                  ra_ff        <= 1'b0;
                  ta_ff        <= 1'b0;
                  state_ff     <= (len_ff == 16'd0) ? S_EMIT : S_IDLE;
               end
            end
            S_WSCAN: begin
               wv_ff <= win_rd;
               if (win_rd) begin
                  k_ff     <= k_ff + WW'(1);
                  wlast_ff <= k_ff == fill_ff - WW'(1);
               end
               if (wv_ff) begin
                  if (win_q_ff.from_a) ca_ff <= ca_ff + WW'(1);
                  else                 cb_ff <= cb_ff + WW'(1);
                  if (win_q_ff.cls == CLASS_SHORT)  sh_ff <= sh_ff + WW'(1);
                  if (win_q_ff.cls == CLASS_MEDIUM) md_ff <= md_ff + WW'(1);
                  if (prev_ok_ff) begin
                     if (gap == 32'd0)      g0_ff <= g0_ff + WW'(1);
                     else if (gap == 32'd1) g1_ff <= g1_ff + WW'(1);
                     else if (gap == 32'd2) g2_ff <= g2_ff + WW'(1);
                     else                   gl_ff <= gl_ff + WW'(1);
                  end
                  prev_time_ff <= win_q_ff.stamp;
                  prev_ok_ff   <= 1'b1;
                  if (wlast_ff) begin
                     state_ff <= S_ALERT;
                  end
               end
            end
            S_ALERT: begin
               sa_ff    <= enough && stim;
               ra_ff    <= enough && lenmix;
               ta_ff    <= enough && timing;
               state_ff <= (len_ff == 16'd0) ? S_EMIT : S_IDLE;
            end
            S_HUPD: begin
               // histogram writes back this cycle
               state_ff <= (rem_ff == 16'd0) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.no_session     <= pend_none_ff;
                  rsp_ff.session_index  <= slot_wide[6:0];
                  rsp_ff.stimulus_alert <= !pend_none_ff && sa_ff;
                  rsp_ff.length_alert   <= !pend_none_ff && ra_ff;
                  rsp_ff.time_alert     <= !pend_none_ff && ta_ff;
                  rsp_ff.content_alert  <= !pend_none_ff && content;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/icd_hist.sv
// ----------------------------------------------------------------------------
// icd_hist: per-packet payload byte histogram
// Read-modify-write of 8-bit counts, tracks how many values exceed the limit.
// ----------------------------------------------------------------------------
module icd_hist (
   input  logic                 clock,
   input  logic                 reset,
   input  icd_pkg::hist_ctl_type ctl,
   input  logic [7:0]           limit,
   output logic                 alert
);
   import icd_pkg::*;

   logic [7:0]            mem [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] seen_ff;
   logic                  upd_ff;
   logic [7:0]            val_ff;
   logic [7:0]            q_ff;
   logic [8:0]            over_ff;
   logic [7:0]            old_cnt;
   logic [7:0]            new_cnt;
   logic                  old_hi;
   logic                  new_hi;

   // entries not touched this packet read as zero
   always_comb begin
      old_cnt = seen_ff[val_ff] ? q_ff : 8'd0;
      new_cnt = old_cnt + 8'd1;
      old_hi  = old_cnt > limit;
      new_hi  = new_cnt > limit;
   end

   always_ff @(posedge clock) begin
      if (ctl.inc) begin
         q_ff   <= mem[ctl.value];
         val_ff <= ctl.value;
      end
      if (upd_ff) begin
         mem[val_ff] <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff  <= 1'b0;
         seen_ff <= '0;
         over_ff <= '0;
      end else begin
         upd_ff <= ctl.inc;
         if (ctl.clear) begin
            seen_ff <= '0;
            over_ff <= '0;
         end else if (upd_ff) begin
            seen_ff[val_ff] <= 1'b1;
            if (new_hi && !old_hi) begin
               over_ff <= over_ff + 9'd1;
            end else if (old_hi && !new_hi) begin
               over_ff <= over_ff - 9'd1;
            end
         end
      end
   end

   assign alert = over_ff != 9'd0;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ICMP covert channel detector
// Drives packets (header + payload bytes) through valid/ready, predicts each
// completed packet's alerts with a behavioral session/window model, and
// compares every result transfer field by field. Thresholds are rewritten
// over the APB-style port between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import icd_pkg::*;

   localparam int SLOTS  = 128;
   localparam int WIN    = 20;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   icmp_covert_channel_detector dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor state ----------------
   logic [15:0] cfg_timeout, cfg_short, cfg_medium;
   logic [4:0]  cfg_min_pkts;
   logic [7:0]  cfg_repeat;

   bit          sess_valid [SLOTS];
   logic [31:0] sess_a [SLOTS], sess_b [SLOTS], sess_seen [SLOTS];
   int unsigned sess_fill [SLOTS];
   bit          win_from_a [SLOTS][WIN];
   logic [1:0]  win_class [SLOTS][WIN];
   logic [31:0] win_time [SLOTS][WIN];
   logic [7:0]  byte_count [256];
   int unsigned cur_slot;
   logic [15:0] bytes_left;
   bit          cur_orphan;

   rsp_type     expected_alerts [$];
   int          error_count = 0;

   function automatic int claim_session(logic [31:0] src, logic [31:0] dst,
                                        logic [31:0] now);
      logic [32:0] expiry;
      for (int i = 0; i < SLOTS; i++)
         if (sess_valid[i] && ((sess_a[i] == src && sess_b[i] == dst) ||
                               (sess_b[i] == src && sess_a[i] == dst))) begin
            sess_seen[i] = now;
            return i;
         end
      for (int i = 0; i < SLOTS; i++) begin
         expiry = {1'b0, sess_seen[i]} + cfg_timeout;
         if (!sess_valid[i] || expiry < {1'b0, now}) begin
            sess_valid[i] = 1'b1;
            sess_a[i] = src;
            sess_b[i] = dst;
            sess_seen[i] = now;
            sess_fill[i] = 0;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic rsp_type packet_alerts();
      rsp_type r;
      int unsigned n_a, n_b, n_sh, n_md, g0, g1, g2, gl, fill, over;
      logic [31:0] d;
      r = '0;
      n_a = 0; n_b = 0; n_sh = 0; n_md = 0; g0 = 0; g1 = 0; g2 = 0; gl = 0;
      over = 0;
      if (cur_orphan) begin
         r.no_session = 1'b1;
         return r;
      end
      fill = sess_fill[cur_slot];
      r.session_index = cur_slot[6:0];
      if (fill >= cfg_min_pkts) begin
         for (int k = 0; k < fill; k++) begin
            if (win_from_a[cur_slot][k]) n_a++; else n_b++;
            if (win_class[cur_slot][k] == CLASS_SHORT) n_sh++;
            else if (win_class[cur_slot][k] == CLASS_MEDIUM) n_md++;
         end
         for (int k = 0; k + 1 < fill; k++) begin
            d = win_time[cur_slot][k+1] - win_time[cur_slot][k];
            if (d == 0) g0++;
            else if (d == 1) g1++;
            else if (d == 2) g2++;
            else gl++;
         end
         r.stimulus_alert = (2*n_a > 3*n_b) || (2*n_a < n_b);
         r.length_alert   = (5*n_sh > n_md) && (n_sh < 5*n_md) && (n_sh > 3);
         r.time_alert     = (g0 > g1 + 3) || (g2 > 6) || (gl > 4);
      end
      for (int k = 0; k < 256; k++)
         if (byte_count[k] > cfg_repeat) over++;
      r.content_alert = (over != 0);
      return r;
   endfunction

   // Advance the predictor by one accepted item; queue a result if it completes.
   function automatic void predict_item(req_type it);
      int s, f;
      logic [1:0] cls;
      if (it.opcode == OP_HEADER) begin
         foreach (byte_count[k]) byte_count[k] = 8'd0;
         bytes_left = it.payload_length;
         s = claim_session(it.source_address, it.dest_address, it.time_seconds);
         if (s < 0) begin
            cur_orphan = 1'b1;
            cur_slot = 0;
         end else begin
            f = sess_fill[s];
            if (f >= WIN - 1) begin
               for (int k = 0; k < WIN - 2; k++) begin
                  win_from_a[s][k] = win_from_a[s][k+1];
                  win_class[s][k]  = win_class[s][k+1];
                  win_time[s][k]   = win_time[s][k+1];
               end
               f = WIN - 2;
            end
            if (it.payload_length < cfg_short) cls = CLASS_SHORT;
            else if (it.payload_length < cfg_medium) cls = CLASS_MEDIUM;
            else cls = CLASS_LONG;
            win_from_a[s][f] = (it.source_address == sess_a[s]);
            win_class[s][f]  = cls;
            win_time[s][f]   = it.time_seconds;
            sess_fill[s] = f + 1;
            cur_orphan = 1'b0;
            cur_slot = s;
         end
         if (it.payload_length == 0) expected_alerts.push_back(packet_alerts());
      end else if (bytes_left != 0) begin
         byte_count[it.payload_byte]++;
         bytes_left--;
         if (bytes_left == 0) expected_alerts.push_back(packet_alerts());
      end
   endfunction

   // ---------------- result checking ----------------
   int idle_cycles = 0;
   bit timed_out = 1'b0;

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_alerts.size() == 0) begin
            $error("result transfer with nothing expected: %p", rsp_data);
            error_count++;
         end else begin
            exp_r = expected_alerts.pop_front();
            if (rsp_data.no_session !== exp_r.no_session) begin
               $error("no_session exp %0d got %0d", exp_r.no_session, rsp_data.no_session);
               error_count++;
            end
            if (rsp_data.session_index !== exp_r.session_index) begin
               $error("session_index exp %0d got %0d",
                      exp_r.session_index, rsp_data.session_index);
               error_count++;
            end
            if (rsp_data.stimulus_alert !== exp_r.stimulus_alert) begin
               $error("stimulus_alert exp %0d got %0d",
                      exp_r.stimulus_alert, rsp_data.stimulus_alert);
               error_count++;
            end
            if (rsp_data.length_alert !== exp_r.length_alert) begin
               $error("length_alert exp %0d got %0d",
                      exp_r.length_alert, rsp_data.length_alert);
               error_count++;
            end
            if (rsp_data.time_alert !== exp_r.time_alert) begin
               $error("time_alert exp %0d got %0d", exp_r.time_alert, rsp_data.time_alert);
               error_count++;
            end
            if (rsp_data.content_alert !== exp_r.content_alert) begin
               $error("content_alert exp %0d got %0d",
                      exp_r.content_alert, rsp_data.content_alert);
               error_count++;
            end
         end
      end
      // watchdog: cycles with no transfer on either channel
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("testbench failed");
         $finish;
      end
   end

   // Receiver: random stalls, mostly short, occasionally long, some runs open.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                          : $urandom_range(1, 8)) @(negedge clock);
         case ($urandom_range(0, 9))
            0:       gap = $urandom_range(20, 80);
            1, 2:    gap = 0;
            default: gap = $urandom_range(1, 4);
         endcase
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_TIMEOUT: cfg_timeout  = value[15:0];
         REG_SHORT:   cfg_short    = value[15:0];
         REG_MEDIUM:  cfg_medium   = value[15:0];
         REG_MINPKT:  cfg_min_pkts = value[4:0];
         REG_REPEAT:  cfg_repeat   = value[7:0];
         default: ;
      endcase
   endtask

   // One input transfer with an optional random gap beforehand.
   task automatic send_item(req_type it, bit allow_gap);
      int gap;
      gap = 0;
      if (allow_gap)
         case ($urandom_range(0, 19))
            0:          gap = $urandom_range(15, 60);
            1, 2, 3, 4: gap = $urandom_range(1, 3);
            default:    gap = 0;
         endcase
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(it);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   function automatic req_type header(logic [31:0] src, logic [31:0] dst,
                                      logic [31:0] t, logic [15:0] len);
      req_type it;
      it = '0;
      it.opcode = OP_HEADER;
      it.source_address = src;
      it.dest_address = dst;
      it.time_seconds = t;
      it.payload_length = len;
      return it;
   endfunction

   function automatic req_type payload(logic [7:0] b);
      req_type it;
      it = '0;
      it.source_address = $urandom;
      it.dest_address = $urandom;
      it.time_seconds = $urandom;
      it.payload_length = 16'($urandom);
      it.opcode = OP_BYTE;
      it.payload_byte = b;
      return it;
   endfunction

   task automatic wait_drained();
      while (expected_alerts.size() != 0) @(negedge clock);
      // an abandoned packet may still be sweeping after the last result
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Directed table: each row is one item; exp_valid rows carry a typed result.
   typedef struct {
      req_type it;
      bit      exp_valid;
      rsp_type exp_r;
   } dir_row_type;

   // Host pair pool keeps sessions recurring so windows fill up.
   logic [31:0] pool_a [16], pool_b [16];
   logic [31:0] clock_s = 32'd1000;
   int items_sent = 0;

   task automatic random_packet(int max_len);
      int p, n;
      logic [15:0] len;
      logic [7:0] fav;
      req_type it;
      p = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
         0:       clock_s += $urandom_range(3, 200);
         1, 2:    clock_s += 2;
         3, 4, 5: clock_s += 1;
         default: ;
      endcase
      if ($urandom_range(0, 30) == 0) clock_s = $urandom;
      len = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3))
                                      : 16'($urandom_range(0, max_len));
      if ($urandom_range(0, 1))
         it = header(pool_a[p], pool_b[p], clock_s, len);
      else
         it = header(pool_b[p], pool_a[p], clock_s, len);
      if ($urandom_range(0, 25) == 0) it.source_address = $urandom;
      send_item(it, 1'b1);
      items_sent++;
      fav = 8'($urandom);
      // truncated packets now and then: abandoned by the next header
      n = ($urandom_range(0, 15) == 0 && len > 1) ? $urandom_range(1, len - 1) : len;
      for (int k = 0; k < n; k++) begin
         send_item(payload($urandom_range(0, 1) ? fav : 8'($urandom)), 1'b1);
         items_sent++;
      end
   endtask

   initial begin
      dir_row_type rows [$];
      dir_row_type row;
      rsp_type r;
      cfg_timeout = RST_TIMEOUT; cfg_short = RST_SHORT; cfg_medium = RST_MEDIUM;
      cfg_min_pkts = RST_MINPKT; cfg_repeat = RST_REPEAT;
      foreach (sess_valid[i]) begin
         sess_valid[i] = 0; sess_seen[i] = 0; sess_fill[i] = 0;
      end
      foreach (byte_count[k]) byte_count[k] = 0;
      cur_slot = 0; bytes_left = 0; cur_orphan = 0;
      foreach (pool_a[i]) begin
         pool_a[i] = $urandom;
         pool_b[i] = $urandom;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part, default thresholds ---
      // stray byte with nothing pending: ignored
      row.it = payload(8'hFF); row.exp_valid = 0; row.exp_r = '0; rows.push_back(row);
      // zero-length header at extremes: fresh slot 0, window of one, no alerts
      row.it = header(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
      row.exp_valid = 1; row.exp_r = '0; rows.push_back(row);
      // same pair reversed: still slot 0
      row.it = header(32'hFFFF_FFFF, 32'h0, 32'h0, 16'd0);
      row.exp_valid = 1; row.exp_r = '0; rows.push_back(row);
      // new pair long after slot 0 went idle: slot 0 reused,
      // seven identical bytes exceed repeat limit 6
      row.it = header(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h8000_0000, 16'd7);
      row.exp_valid = 0; rows.push_back(row);
      for (int k = 0; k < 7; k++) begin
         row.it = payload(8'hAA); row.exp_valid = (k == 6);
         r = '0; r.session_index = 7'd0; r.content_alert = 1; row.exp_r = r;
         rows.push_back(row);
      end
      // header abandoning a pending packet, then a full-range byte
      row.it = header(32'h1, 32'h2, 32'h7FFF_FFFF, 16'hFFFF); row.exp_valid = 0;
      rows.push_back(row);
      row.it = payload(8'h00); row.exp_valid = 0; rows.push_back(row);
      row.it = header(32'h1, 32'h2, 32'h8000_0000, 16'd1); row.exp_valid = 0;
      rows.push_back(row);
      row.it = payload(8'h55); row.exp_valid = 0; rows.push_back(row);
      // opcode-wide sweep: a header with a long length, abandoned again
      row.it = header(32'h3, 32'h4, 32'h0, 16'd600); row.exp_valid = 0; rows.push_back(row);
      foreach (rows[i]) begin
         if (rows[i].exp_valid) begin
            // predictor must agree with the typed value that it queued
            send_item(rows[i].it, 1'b0);
            r = expected_alerts[expected_alerts.size() - 1];
            if (r !== rows[i].exp_r) begin
               $error("directed row %0d: exp %p predicted %p", i, rows[i].exp_r, r);
               error_count++;
            end
         end else
            send_item(rows[i].it, 1'b0);
      end
      items_sent += rows.size();
      // rapid same-pair packets fill the window past full (time alert, same second)
      for (int k = 0; k < 22; k++) begin
         send_item(header(32'h10, 32'h20, 32'd5, 16'd0), 1'b0);
         items_sent++;
      end
      end_burst();
      wait_drained();

      // --- threshold sweep with extremes ---
      csr_write(REG_TIMEOUT, 32'd0);
      csr_write(REG_SHORT, 32'd65535);
      csr_write(REG_MEDIUM, 32'd65535);
      csr_write(REG_MINPKT, 32'd1);
      csr_write(REG_REPEAT, 32'd0);
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 90; k++) random_packet(6);
         end_burst();
         wait_drained();
         case (p)
            0: begin
               csr_write(REG_TIMEOUT, 32'd65535);
               csr_write(REG_SHORT, 32'd0);
               csr_write(REG_MEDIUM, 32'd0);
               csr_write(REG_MINPKT, 32'd19);
               csr_write(REG_REPEAT, 32'd255);
            end
            1: begin
               csr_write(REG_TIMEOUT, 32'd3);
               csr_write(REG_SHORT, 32'd2);
               csr_write(REG_MEDIUM, 32'd5);
               csr_write(REG_MINPKT, 32'd4);
               csr_write(REG_REPEAT, 32'd2);
            end
            2: begin
               csr_write(REG_TIMEOUT, 32'($urandom_range(0, 65535)));
               csr_write(REG_SHORT, 32'($urandom_range(0, 4)));
               csr_write(REG_MEDIUM, 32'($urandom_range(3, 12)));
               csr_write(REG_MINPKT, 32'($urandom_range(1, 19)));
               csr_write(REG_REPEAT, 32'($urandom_range(0, 255)));
            end
            default: ;
         endcase
      end
      // table fill with fresh pairs and no expiry: exercises the full-table case
      csr_write(REG_TIMEOUT, 32'd65535);
      for (int k = 0; k < 140; k++) begin
         send_item(header($urandom, $urandom, clock_s, 16'd0), 1'b1);
         items_sent++;
      end
      end_burst();
      wait_drained();
      // a few large packets with default thresholds
      csr_write(REG_TIMEOUT, 32'd60);
      csr_write(REG_SHORT, 32'd20);
      csr_write(REG_MEDIUM, 32'd500);
      csr_write(REG_MINPKT, 32'd6);
      csr_write(REG_REPEAT, 32'd6);
      clock_s += 100000;
      while (items_sent < 1550) random_packet(($urandom_range(0, 40) == 0) ? 600 : 30);
      end_burst();
      wait_drained();

      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

>>> files.f
rtl/icd_pkg.sv
rtl/icd_hist.sv
rtl/icmp_covert_channel_detector.sv
sim/testbench.sv
